/* rtl/bdeq_pkg.sv */
package bdeq_pkg;

  localparam int unsigned DEPTH_DEF  = 1024;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_TDATA_W = 32;

  // request kinds; unused codes act as query only
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

/* rtl/bounded_double_ended_queue_core.sv */
// result path: an accepted request waits in the in-flight registers, then moves into the output
// register; it waits longer while the output register still holds an unaccepted result
// a new request is not taken while a request is in flight, whether or not it reads the element store
// a new request is taken while the previous result still waits on the output register
// reset (rst_n, synchronous, active low) empties the deque and drops any pending result
// the element store is not cleared; only occupied entries are ever read
module bounded_double_ended_queue_core #(
  parameter int unsigned DEPTH = bdeq_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1),
  localparam int unsigned OUT_BITS    = 3 * bdeq_pkg::DATA_W + bdeq_pkg::STATUS_W + CNT_W + 1,
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdeq_pkg::IN_TDATA_W-1:0] in_tdata,   // value
  input  logic [bdeq_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_value, status, count, is_empty, front_value, back_value
  output logic [OUT_TDATA_W-1:0]          out_tdata
);
  import bdeq_pkg::*;

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned ST_LSB  = DATA_W;
  localparam int unsigned CNT_LSB = ST_LSB + STATUS_W;
  localparam int unsigned EMP_BIT = CNT_LSB + CNT_W;
  localparam int unsigned FR_LSB  = EMP_BIT + 1;
  localparam int unsigned BK_LSB  = FR_LSB + DATA_W;

  // deque pointers: head is the front slot, tail the back slot
  // invariant: tail == head + count - 1 (mod DEPTH), also when empty
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // cached copies of the front and back elements
  logic [DATA_W-1:0] front_r, front_nxt;
  logic [DATA_W-1:0] back_r, back_nxt;

  // request in flight between accept and result
  logic              busy_r, busy_nxt;
  logic              rd_front_r, rd_front_nxt;  // new front comes from the store read
  logic              rd_back_r, rd_back_nxt;    // new back comes from the store read
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // store port signals
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              in_acc;
  logic              done;
  logic              is_full;
  logic              is_empty;
  logic              last_one;
  kind_t             kind;
  logic [DATA_W-1:0] value;
  logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic [DATA_W-1:0] res_front, res_back;

  assign in_tready  = !busy_r;
  assign in_acc     = in_tvalid && in_tready;
  // result moves into the output register once that register is free or its result is taken
  assign done       = busy_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  assign kind     = kind_t'(in_tuser);
  assign value    = in_tdata[DATA_W-1:0];
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign last_one = (count_r == CNT_W'(1));

  // circular index steps, valid for any depth of two or more
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? IDX_W'(DEPTH - 1) : tail_r - 1'b1;

  // a pop takes the removed element from the cache and, unless it was the last one, reads its neighbor
  // from the store; a push writes the store and updates the cache directly
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    busy_nxt     = busy_r;
    rd_front_nxt = rd_front_r;
    rd_back_nxt  = rd_back_r;
    status_nxt   = status_r;
    popped_nxt   = popped_r;
    wr_en        = 1'b0;
    wr_addr      = head_dec;
    rd_en        = 1'b0;
    rd_addr      = head_inc;

    if (in_acc) begin
      busy_nxt     = 1'b1;
      rd_front_nxt = 1'b0;
      rd_back_nxt  = 1'b0;
      status_nxt   = ST_OK;
      popped_nxt   = '0;
      unique case (kind)
        KIND_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
            front_nxt = value;
            if (is_empty) begin
              back_nxt = value;
            end
          end
        end
        KIND_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_inc;
            tail_nxt  = tail_inc;
            count_nxt = count_r + 1'b1;
            back_nxt  = value;
            if (is_empty) begin
              front_nxt = value;
            end
          end
        end
        KIND_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = front_r;
            head_nxt   = head_inc;
            count_nxt  = count_r - 1'b1;
            if (last_one) begin
              front_nxt = '0;
              back_nxt  = '0;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = head_inc;
              rd_front_nxt = 1'b1;
            end
          end
        end
        KIND_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = back_r;
            tail_nxt   = tail_dec;
            count_nxt  = count_r - 1'b1;
            if (last_one) begin
              front_nxt = '0;
              back_nxt  = '0;
            end else begin
              rd_en       = 1'b1;
              rd_addr     = tail_dec;
              rd_back_nxt = 1'b1;
            end
          end
        end
        default: begin
          // query only, also the unused kind codes
        end
      endcase
    end else if (done) begin
      busy_nxt     = 1'b0;
      rd_front_nxt = 1'b0;
      rd_back_nxt  = 1'b0;
      if (rd_front_r) begin
        front_nxt = rd_data;
      end
      if (rd_back_r) begin
        back_nxt = rd_data;
      end
    end
  end

  assign res_front = rd_front_r ? rd_data : front_r;
  assign res_back  = rd_back_r ? rd_data : back_r;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    if (done) begin
      out_valid_nxt                       = 1'b1;
      out_tdata_nxt                       = '0;
      out_tdata_nxt[0 +: DATA_W]          = popped_r;
      out_tdata_nxt[ST_LSB +: STATUS_W]   = status_r;
      out_tdata_nxt[CNT_LSB +: CNT_W]     = count_r;
      out_tdata_nxt[EMP_BIT]              = is_empty;
      out_tdata_nxt[FR_LSB +: DATA_W]     = res_front;
      out_tdata_nxt[BK_LSB +: DATA_W]     = res_back;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= IDX_W'(DEPTH - 1);
      count_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      busy_r      <= 1'b0;
      rd_front_r  <= 1'b0;
      rd_back_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      busy_r      <= busy_nxt;
      rd_front_r  <= rd_front_nxt;
      rd_back_r   <= rd_back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    popped_r    <= popped_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  bdeq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted request not in flight");

  a_read_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_front_r || rd_back_r) |-> busy_r && !(rd_front_r && rd_back_r))
    else $error("store read pending without a request");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1
                || count_r == $past(count_r) - 1'b1))
    else $error("count moved by more than one");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[EMP_BIT]) |->
      (out_tdata[FR_LSB +: DATA_W] == '0 && out_tdata[BK_LSB +: DATA_W] == '0))
    else $error("empty result with nonzero front or back");

endmodule

/* rtl/bdeq_store.sv */
module bdeq_store #(
  parameter int unsigned DEPTH = bdeq_pkg::DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [bdeq_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [bdeq_pkg::DATA_W-1:0] rd_data_r
);
  import bdeq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
